// ----- design/ddo_pkg.sv -----
// Shared types, constants and the lookup function of the differential-drive odometry block.
package ddo_pkg;

  // Input item kinds.
  typedef enum logic [1:0] {
    MODE_WHEEL1  = 2'd0,
    MODE_WHEEL2  = 2'd1,
    MODE_UPDATE  = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  // Configuration register indexes (word addresses).
  typedef enum logic [1:0] {
    REG_METERS_PER_TICK = 2'd0,
    REG_INV_WHEEL_BASE  = 2'd1,
    REG_MIN_INTERVAL    = 2'd2
  } reg_idx_t;

  localparam int CFG_ADDR_WIDTH = 4;
  localparam logic [9:0] MIN_INTERVAL_RESET = 10'd10;

  localparam int DEF_COUNT_WIDTH = 32;
  localparam int DEF_ANGLE_WIDTH = 32;
  localparam int QUEUE_DEPTH     = 2;

  // Radians (Q24) to binary angle scale, and CORDIC gain compensation (Q30).
  localparam logic [31:0] RAD_TO_BAM_Q24  = 32'd683565276;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032875;
  localparam int CORDIC_STEPS = 24;

  // Job handed from the front to the back: a restart, or an update with
  // the snapshot of both tick counts and the elapsed interval.
  typedef struct packed {
    logic               restart;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic [31:0]        dt;
  } job_t;

  // Arctangent of 2^-i as a binary angle.
  function automatic logic [29:0] atan_bam(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667332;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/ddo_ifs.sv -----
// Valid/ready channel interfaces for the odometry input items and results.
interface ddo_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        chan_a;
  logic        chan_b;
  logic [31:0] now_ms;

  modport source (output valid, mode, chan_a, chan_b, now_ms, input ready);
  modport sink (input valid, mode, chan_a, chan_b, now_ms, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [31:0]        heading;
  logic signed [31:0] wheel1_speed;
  logic signed [31:0] wheel2_speed;
  logic [31:0]        interval_ms;

  modport source (output valid, pose_x, pose_y, heading, wheel1_speed, wheel2_speed,
                  interval_ms, input ready);
  modport sink (input valid, pose_x, pose_y, heading, wheel1_speed, wheel2_speed,
                interval_ms, output ready);
endinterface

// ----- design/ddo_front.sv -----
// Front end: counts wheel edges, gates updates by interval and queues jobs.
module ddo_front #(
  parameter int COUNT_WIDTH = ddo_pkg::DEF_COUNT_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  ddo_in_if.sink        in_ch,
  input  logic [9:0]    min_interval,
  input  logic          q_full,
  output logic          q_push,
  output ddo_pkg::job_t q_job
);
  import ddo_pkg::*;

  logic [COUNT_WIDTH-1:0] w1_cnt_r, w1_cnt_nxt;
  logic [COUNT_WIDTH-1:0] w2_cnt_r, w2_cnt_nxt;
  logic [31:0]            last_r, last_nxt;
  logic [COUNT_WIDTH-1:0] step;
  logic [31:0]            dt;
  logic                   xfer;
  logic                   take_update;

  assign in_ch.ready = !q_full;
  assign xfer        = in_ch.valid && in_ch.ready;

  // One tick forward when the channels agree, one back otherwise.
  assign step = (in_ch.chan_a == in_ch.chan_b) ? COUNT_WIDTH'(1) : {COUNT_WIDTH{1'b1}};
  assign dt   = in_ch.now_ms - last_r;
  assign take_update = (in_ch.mode == MODE_UPDATE) && (dt >= {22'd0, min_interval});

  // A restart or an update that is due becomes a job for the back end.
  assign q_push        = xfer && ((in_ch.mode == MODE_RESTART) || take_update);
  assign q_job.restart = (in_ch.mode == MODE_RESTART);
  assign q_job.c1      = 32'(signed'(w1_cnt_r));
  assign q_job.c2      = 32'(signed'(w2_cnt_r));
  assign q_job.dt      = dt;

  // Next-state logic for the counters and the interval timer.
  always_comb begin
    w1_cnt_nxt = w1_cnt_r;
    w2_cnt_nxt = w2_cnt_r;
    last_nxt   = last_r;
    if (xfer) begin
      case (in_ch.mode)
        MODE_WHEEL1: w1_cnt_nxt = w1_cnt_r + step;
        MODE_WHEEL2: w2_cnt_nxt = w2_cnt_r + step;
        MODE_UPDATE: begin
          if (take_update) begin
            w1_cnt_nxt = '0;
            w2_cnt_nxt = '0;
            last_nxt   = in_ch.now_ms;
          end
        end
        MODE_RESTART: last_nxt = in_ch.now_ms;
        default: last_nxt = last_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_cnt_r <= '0;
      w2_cnt_r <= '0;
      last_r   <= '0;
    end else begin
      w1_cnt_r <= w1_cnt_nxt;
      w2_cnt_r <= w2_cnt_nxt;
      last_r   <= last_nxt;
    end
  end

endmodule

// ----- design/ddo_queue.sv -----
// Short job queue that decouples the front end from the back end.
module ddo_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ddo_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output ddo_pkg::job_t pop_job
);
  import ddo_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH)) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count lost a push");
`endif

endmodule

// ----- design/ddo_back.sv -----
// Back end: speed divider, heading step, CORDIC and pose update with result register.
module ddo_back #(
  parameter int ANGLE_WIDTH = ddo_pkg::DEF_ANGLE_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [31:0]   meters_per_tick,
  input  logic [31:0]   inv_wheel_base,
  input  logic          q_empty,
  input  ddo_pkg::job_t q_job,
  output logic          q_pop,
  ddo_out_if.source     out_ch
);
  import ddo_pkg::*;

  localparam logic [31:0] ANG_MASK = {32{1'b1}} << (32 - ANGLE_WIDTH);
  localparam int DIV_BITS = 58;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SPD_MUL, ST_SPD_NUM, ST_SPD_DIV, ST_SPD_SAT,
    ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7,
    ST_CORDIC,
    ST_D0, ST_D1, ST_D2, ST_D3, ST_D4, ST_D5, ST_D6, ST_D7,
    ST_EMIT
  } state_t;

  state_t               state_r;
  logic signed [31:0]   c1_r, c2_r;
  logic [31:0]          dt_r;
  logic                 wsel_r;
  logic [63:0]          prod_r;
  logic [63:0]          acc_r;
  logic [63:0]          tmp_r;
  logic [DIV_BITS-1:0]  num_r;
  logic [DIV_BITS-1:0]  quo_r;
  logic [32:0]          rem_r;
  logic [5:0]           cnt_r;
  logic signed [33:0]   cx_r, cy_r, cz_r;
  logic                 flip_r;
  logic signed [31:0]   pos_x_r, pos_y_r;
  logic [31:0]          angle_r;
  logic signed [31:0]   spd1_r, spd2_r;
  logic                 out_valid_r;
  logic signed [31:0]   out_x_r, out_y_r, out_s1_r, out_s2_r;
  logic [31:0]          out_head_r, out_int_r;

  logic [31:0]          op_a, op_b;
  logic signed [32:0]   diff, sum, cur_c;
  logic [32:0]          diff_mag, sum_mag;
  logic [31:0]          cur_mag;
  logic signed [33:0]   cos_v, sin_v;
  logic [31:0]          cos_mag, sin_mag;
  logic                 cur_neg;
  logic [73:0]          n74;
  logic [32:0]          trial;
  logic                 trial_ge;
  logic [31:0]          spd_sat;
  logic [63:0]          rad;
  logic [31:0]          bam, bam_s, angle_sum, rot;
  logic signed [33:0]   cdx, cdy, catan;
  logic [63:0]          step_mag;
  logic signed [63:0]   step_s, pos_sum;
  logic                 step_neg;
  logic signed [31:0]   pos_cur, pos_new;
  logic                 out_free;

  // Signed sums and magnitudes of the tick snapshot.
  assign diff     = 33'(c2_r) - 33'(c1_r);
  assign sum      = 33'(c1_r) + 33'(c2_r);
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign sum_mag  = sum[32] ? 33'(-sum) : 33'(sum);
  assign cur_c    = wsel_r ? 33'(c2_r) : 33'(c1_r);
  assign cur_neg  = cur_c[32];
  assign cur_mag  = cur_neg ? 32'(-cur_c) : cur_c[31:0];

  // CORDIC outputs folded back to the original half-plane.
  assign cos_v   = flip_r ? -cx_r : cx_r;
  assign sin_v   = flip_r ? -cy_r : cy_r;
  assign cos_mag = cos_v[33] ? 32'(-cos_v) : cos_v[31:0];
  assign sin_mag = sin_v[33] ? 32'(-sin_v) : sin_v[31:0];

  // Shared 32x32 multiplier; product is registered before use.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      ST_SPD_MUL: begin op_a = cur_mag;            op_b = meters_per_tick; end
      ST_H0:      begin op_a = diff_mag[31:0];     op_b = meters_per_tick; end
      ST_H2:      begin op_a = acc_r[31:0];        op_b = inv_wheel_base;  end
      ST_H3:      begin op_a = acc_r[63:32];       op_b = inv_wheel_base;  end
      ST_H5:      begin op_a = acc_r[31:0];        op_b = RAD_TO_BAM_Q24;  end
      ST_H6:      begin op_a = {8'd0, acc_r[55:32]}; op_b = RAD_TO_BAM_Q24; end
      ST_D0:      begin op_a = sum_mag[31:0];      op_b = meters_per_tick; end
      ST_D2:      begin op_a = acc_r[31:0];        op_b = cos_mag;         end
      ST_D3:      begin op_a = acc_r[63:32];       op_b = cos_mag;         end
      ST_D5:      begin op_a = acc_r[31:0];        op_b = sin_mag;         end
      ST_D6:      begin op_a = acc_r[63:32];       op_b = sin_mag;         end
      default:    begin op_a = '0;                 op_b = '0;              end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // Speed: numerator 1000*m/2^16, one restoring divide step per cycle.
  assign n74      = ({10'd0, prod_r} << 10) - ({10'd0, prod_r} << 4) - ({10'd0, prod_r} << 3);
  assign trial    = {rem_r[31:0], num_r[DIV_BITS-1]};
  assign trial_ge = (trial >= {1'b0, dt_r});
  always_comb begin
    if (cur_neg) begin
      spd_sat = (quo_r > DIV_BITS'(64'h8000_0000)) ? 32'h8000_0000 : 32'(-quo_r);
    end else begin
      spd_sat = (quo_r > DIV_BITS'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo_r[31:0];
    end
  end

  // Heading step: radians times 2^32/(2pi), bits 24..55 kept.
  assign rad       = prod_r + {32'd0, tmp_r[63:32]};
  assign bam       = tmp_r[55:24] + {prod_r[23:0], 8'd0};
  assign bam_s     = diff[32] ? -bam : bam;
  assign angle_sum = (angle_r + bam_s) & ANG_MASK;
  assign rot       = (angle_sum[31:30] == 2'b01 || angle_sum[31:30] == 2'b10)
                     ? angle_sum - 32'h8000_0000 : angle_sum;

  // CORDIC rotation step.
  assign cdx   = cy_r >>> cnt_r[4:0];
  assign cdy   = cx_r >>> cnt_r[4:0];
  assign catan = 34'(atan_bam(cnt_r[4:0]));

  // Pose step: distance times |cos| or |sin| in Q30, then saturated add.
  assign step_mag = (prod_r << 2) + {30'd0, tmp_r[63:30]};
  assign step_neg = (state_r == ST_D4) ? (sum[32] != cos_v[33]) : (sum[32] != sin_v[33]);
  assign step_s   = step_neg ? -signed'(step_mag) : signed'(step_mag);
  assign pos_cur  = (state_r == ST_D4) ? pos_x_r : pos_y_r;
  assign pos_sum  = 64'(pos_cur) + step_s;
  always_comb begin
    if (pos_sum > 64'sh7FFF_FFFF) begin
      pos_new = 32'sh7FFF_FFFF;
    end else if (pos_sum < -64'sh8000_0000) begin
      pos_new = -32'sh8000_0000;
    end else begin
      pos_new = pos_sum[31:0];
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pose_x       = out_x_r;
  assign out_ch.pose_y       = out_y_r;
  assign out_ch.heading      = out_head_r;
  assign out_ch.wheel1_speed = out_s1_r;
  assign out_ch.wheel2_speed = out_s2_r;
  assign out_ch.interval_ms  = out_int_r;

  // Sequencer with pose state and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      angle_r     <= '0;
      spd1_r      <= '0;
      spd2_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The emit state reloads the result register itself when it is taken.
      if (out_valid_r && out_ch.ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            c1_r   <= q_job.c1;
            c2_r   <= q_job.c2;
            wsel_r <= 1'b0;
            if (q_job.restart) begin
              pos_x_r <= '0;
              pos_y_r <= '0;
              dt_r    <= '0;
              state_r <= ST_EMIT;
            end else begin
              dt_r    <= q_job.dt;
              state_r <= ST_SPD_MUL;
            end
          end
        end
        ST_SPD_MUL: state_r <= ST_SPD_NUM;
        ST_SPD_NUM: begin
          num_r   <= n74[73:16];
          rem_r   <= '0;
          quo_r   <= '0;
          cnt_r   <= 6'(DIV_BITS);
          state_r <= (dt_r == '0) ? ST_SPD_SAT : ST_SPD_DIV;
        end
        ST_SPD_DIV: begin
          rem_r <= trial_ge ? trial - {1'b0, dt_r} : trial;
          quo_r <= {quo_r[DIV_BITS-2:0], trial_ge};
          num_r <= num_r << 1;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            state_r <= ST_SPD_SAT;
          end
        end
        ST_SPD_SAT: begin
          if (wsel_r) begin
            spd2_r  <= signed'(spd_sat);
            state_r <= ST_H0;
          end else begin
            spd1_r  <= signed'(spd_sat);
            wsel_r  <= 1'b1;
            state_r <= ST_SPD_MUL;
          end
        end
        ST_H0: state_r <= ST_H1;
        ST_H1: begin
          acc_r   <= prod_r + (diff_mag[32] ? {meters_per_tick, 32'd0} : 64'd0);
          state_r <= ST_H2;
        end
        ST_H2: state_r <= ST_H3;
        ST_H3: begin
          tmp_r   <= prod_r;
          state_r <= ST_H4;
        end
        ST_H4: begin
          acc_r   <= rad;
          state_r <= ST_H5;
        end
        ST_H5: state_r <= ST_H6;
        ST_H6: begin
          tmp_r   <= prod_r;
          state_r <= ST_H7;
        end
        ST_H7: begin
          angle_r <= angle_sum;
          flip_r  <= (angle_sum[31:30] == 2'b01 || angle_sum[31:30] == 2'b10);
          cx_r    <= CORDIC_GAIN_Q30;
          cy_r    <= '0;
          cz_r    <= 34'(signed'(rot));
          cnt_r   <= '0;
          state_r <= ST_CORDIC;
        end
        ST_CORDIC: begin
          if (!cz_r[33]) begin
            cx_r <= cx_r - cdx;
            cy_r <= cy_r + cdy;
            cz_r <= cz_r - catan;
          end else begin
            cx_r <= cx_r + cdx;
            cy_r <= cy_r - cdy;
            cz_r <= cz_r + catan;
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(CORDIC_STEPS - 1)) begin
            state_r <= ST_D0;
          end
        end
        ST_D0: state_r <= ST_D1;
        ST_D1: begin
          acc_r   <= (prod_r + (sum_mag[32] ? {meters_per_tick, 32'd0} : 64'd0)) >> 17;
          state_r <= ST_D2;
        end
        ST_D2: state_r <= ST_D3;
        ST_D3: begin
          tmp_r   <= prod_r;
          state_r <= ST_D4;
        end
        ST_D4: begin
          pos_x_r <= pos_new;
          state_r <= ST_D5;
        end
        ST_D5: state_r <= ST_D6;
        ST_D6: begin
          tmp_r   <= prod_r;
          state_r <= ST_D7;
        end
        ST_D7: begin
          pos_y_r <= pos_new;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= pos_x_r;
            out_y_r     <= pos_y_r;
            out_head_r  <= angle_r;
            out_s1_r    <= spd1_r;
            out_s2_r    <= spd2_r;
            out_int_r   <= dt_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/diff_drive_odometry_unit.sv -----
// Top level of the differential-drive odometry block with its register port.
//
// Wheel edge items are counted by the front end and cause no result.
// Update and restart items pass through a two-entry job queue to a sequential back end.
// A restart also gives a result. An accepted update gives its result after two 58-step
// restoring divisions for the wheel speeds (one quotient bit per cycle, skipped when the
// interval is zero), a 24-step CORDIC for cosine and sine, and a dozen steps on one
// shared 32x32 multiplier. A result that waits on the output holds the back end until
// it goes. Updates arriving closer than min_interval_ms are dropped in the front end
// without a result. Edges keep being accepted while the back end works, until the
// queue fills.
module diff_drive_odometry_unit #(
  parameter int COUNT_WIDTH = ddo_pkg::DEF_COUNT_WIDTH,
  parameter int ANGLE_WIDTH = ddo_pkg::DEF_ANGLE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ddo_in_if.sink                              in_ch,
  ddo_out_if.source                           out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ddo_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import ddo_pkg::*;

  logic [31:0] mpt_r, iwb_r;
  logic [9:0]  min_int_r;
  logic        cfg_wr;
  reg_idx_t    reg_sel;
  logic        q_push, q_pop, q_full, q_empty;
  job_t        push_job, pop_job;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  // Register writes on the access phase of a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_r     <= '0;
      iwb_r     <= '0;
      min_int_r <= MIN_INTERVAL_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_METERS_PER_TICK: mpt_r     <= pwdata;
        REG_INV_WHEEL_BASE:  iwb_r     <= pwdata;
        REG_MIN_INTERVAL:    min_int_r <= pwdata[9:0];
        default:             mpt_r     <= mpt_r;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      REG_METERS_PER_TICK: prdata = mpt_r;
      REG_INV_WHEEL_BASE:  prdata = iwb_r;
      REG_MIN_INTERVAL:    prdata = {22'd0, min_int_r};
      default:             prdata = '0;
    endcase
  end

  ddo_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .min_interval (min_int_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  ddo_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  ddo_back #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .meters_per_tick (mpt_r),
    .inv_wheel_base  (iwb_r),
    .q_empty         (q_empty),
    .q_job           (pop_job),
    .q_pop           (q_pop),
    .out_ch          (out_ch)
  );

endmodule
